// ----- hdl/button_press_hold_repeat_detector_defines.svh -----
// assertion macros shared by the detector's rtl files
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef BUTTON_PRESS_HOLD_REPEAT_DETECTOR_DEFINES_SVH
`define BUTTON_PRESS_HOLD_REPEAT_DETECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked outside reset
`define BPHR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define BPHR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define BPHR_ASSERT_NOW(label, ante, cons, msg)
`define BPHR_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- hdl/bphr_pkg.sv -----
// shared types and constants for the button press/hold/repeat detector
// no dependencies
`default_nettype none

package bphr_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned MS_W    = 8;
	localparam int unsigned EVENT_W = 3;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 8;
	localparam int unsigned S_TDATA_W = 40;
	localparam int unsigned M_TDATA_W = 8;

	typedef enum logic [EVENT_W-1:0] {
		EV_NONE    = 3'd0,
		EV_PRESS   = 3'd1,
		EV_HOLD    = 3'd2,
		EV_REPEAT  = 3'd3,
		EV_RELEASE = 3'd4
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACTIVE_LOW        = 3'd0,
		REG_DEBOUNCE_MS       = 3'd1,
		REG_HOLD_MS           = 3'd2,
		REG_REPEAT_MS         = 3'd3,
		REG_PRESS_BEFORE_HOLD = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic            active_low;
		logic [MS_W-1:0] debounce_ms;
		logic [MS_W-1:0] hold_ms;
		logic [MS_W-1:0] repeat_ms;
		logic            press_before_hold;
	} cfg_t;

endpackage

`default_nettype wire

// ----- hdl/bphr_cfg.sv -----
// configuration register file of the detector
// depends on bphr_pkg
`default_nettype none

module bphr_cfg
	import bphr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  we,
	input  wire logic [CFG_IDX_W-1:0]  index,
	input  wire logic [CFG_DATA_W-1:0] wdata,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_low        <= 1'b1;
			cfg_q.debounce_ms       <= 8'd50;
			cfg_q.hold_ms           <= 8'd200;
			cfg_q.repeat_ms         <= 8'd100;
			cfg_q.press_before_hold <= 1'b0;
		end else if (we) begin
			unique case (index)
				REG_ACTIVE_LOW:        cfg_q.active_low        <= wdata[0];
				REG_DEBOUNCE_MS:       cfg_q.debounce_ms       <= wdata;
				REG_HOLD_MS:           cfg_q.hold_ms           <= wdata;
				REG_REPEAT_MS:         cfg_q.repeat_ms         <= wdata;
				REG_PRESS_BEFORE_HOLD: cfg_q.press_before_hold <= wdata[0];
				default: ; // unmapped index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- hdl/bphr_core.sv -----
// debounce and press/hold/repeat state with its one-step update logic
// depends on bphr_pkg and the assertion macro header
`default_nettype none
`include "button_press_hold_repeat_detector_defines.svh"

module bphr_core
	import bphr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic              level,
	input  wire logic [TIME_W-1:0] now,
	input  cfg_t                   cfg,
	output event_t                 ev
);

	logic              stable_q, hold_armed_q, in_hold_q, repeat_active_q;
	logic [TIME_W-1:0] change_stamp_q, press_stamp_q, repeat_stamp_q;

	logic              stable_d, hold_armed_d, in_hold_d, repeat_active_d;
	logic [TIME_W-1:0] change_stamp_d, press_stamp_d, repeat_stamp_d;
	event_t            ev_d;

	always_comb begin
		logic              pressed;
		logic [TIME_W-1:0] since_change;
		logic [TIME_W-1:0] since_press;
		logic [TIME_W-1:0] since_repeat;

		pressed         = cfg.active_low ? ~level : level;
		stable_d        = stable_q;
		hold_armed_d    = hold_armed_q;
		in_hold_d       = in_hold_q;
		repeat_active_d = repeat_active_q;
		change_stamp_d  = change_stamp_q;
		press_stamp_d   = press_stamp_q;
		repeat_stamp_d  = repeat_stamp_q;
		ev_d            = EV_NONE;

		// debounce: settle only after a quiet gap longer than debounce_ms
		since_change = now - change_stamp_q;
		if (pressed != stable_q) begin
			if (since_change > {{(TIME_W-MS_W){1'b0}}, cfg.debounce_ms}) begin
				stable_d = pressed;
				if (pressed) begin
					if (cfg.press_before_hold)
						ev_d = EV_PRESS;
					hold_armed_d  = 1'b1;
					press_stamp_d = now;
				end else begin
					if (in_hold_q)
						ev_d = EV_RELEASE;
					else if (!cfg.press_before_hold)
						ev_d = EV_PRESS;
					hold_armed_d    = 1'b0;
					in_hold_d       = 1'b0;
					repeat_active_d = 1'b0;
				end
			end
			change_stamp_d = now;
		end

		// hold and repeat follow the raw pressed flag
		since_press = now - press_stamp_d;
		if (pressed && hold_armed_d &&
		    since_press >= {{(TIME_W-MS_W){1'b0}}, cfg.hold_ms}) begin
			hold_armed_d    = 1'b0;
			in_hold_d       = 1'b1;
			ev_d            = EV_HOLD;
			repeat_stamp_d  = now;
			repeat_active_d = 1'b1;
		end
		since_repeat = now - repeat_stamp_d;
		if (pressed && repeat_active_d &&
		    since_repeat >= {{(TIME_W-MS_W){1'b0}}, cfg.repeat_ms}) begin
			repeat_stamp_d = now;
			ev_d           = EV_REPEAT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q        <= 1'b0;
			hold_armed_q    <= 1'b0;
			in_hold_q       <= 1'b0;
			repeat_active_q <= 1'b0;
			change_stamp_q  <= '0;
			press_stamp_q   <= '0;
			repeat_stamp_q  <= '0;
		end else if (step) begin
			stable_q        <= stable_d;
			hold_armed_q    <= hold_armed_d;
			in_hold_q       <= in_hold_d;
			repeat_active_q <= repeat_active_d;
			change_stamp_q  <= change_stamp_d;
			press_stamp_q   <= press_stamp_d;
			repeat_stamp_q  <= repeat_stamp_d;
		end
	end

	assign ev = ev_d;

	// armed and in-hold are phases of one press, never both
	`BPHR_ASSERT_NOW(a_arm_excl_hold, hold_armed_q, !in_hold_q, "armed while in hold")
	// repeats run exactly while the hold phase lasts
	`BPHR_ASSERT_NOW(a_repeat_tracks_hold, 1'b1, repeat_active_q == in_hold_q,
		"repeat flag out of step with hold")
	// a hold start leaves the block in hold
	`BPHR_ASSERT_NEXT(a_hold_enters, step && ev_d == EV_HOLD, in_hold_q && stable_q,
		"hold start did not enter hold")

endmodule

`default_nettype wire

// ----- hdl/button_press_hold_repeat_detector.sv -----
// top level: button debounce with press, hold start, hold repeat and release events
// depends on bphr_pkg, bphr_cfg, bphr_core and the assertion macro header
//
//  channel   dir  handshake          payload (low bit up)
//  s_*       in   s_tvalid/s_tready  s_tdata: pin_level[0], now_ms[32:1], zero [39:33]
//  m_*       out  m_tvalid/m_tready  m_tdata: event_code[2:0], zero [7:3]
//  cfg_*     in   cfg_we             cfg_index selects register, cfg_wdata value
//
// one word per cycle while m_tready is high; each word gives exactly one result word
// each word passes the input register, then the state update and result register
// the debounce/hold/repeat state update is combinational (three 32-bit subtract/compares)
// s_tready stays high while the result register is free or drains in the same cycle
// a stalled m side holds one word in the result register and one in the input register
// arst_n clears valid flags and core state; configuration returns to its power-on values
`default_nettype none
`include "button_press_hold_repeat_detector_defines.svh"

module button_press_hold_repeat_detector
	import bphr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// input words
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [S_TDATA_W-1:0]  s_tdata,   // pin_level, now_ms, zero pad
	// result words
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [M_TDATA_W-1:0]       m_tdata,   // event_code, zero pad
	// configuration writes
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t cfg;

	// input register
	logic              valid_s1;
	logic              level_s1;
	logic [TIME_W-1:0] now_s1;

	// result register
	logic   out_valid_q;
	event_t event_q;

	logic   advance;
	event_t ev;

	bphr_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	// the staged word moves into the result register when that register is free or drains
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			level_s1 <= s_tdata[0];
			now_s1   <= s_tdata[TIME_W:1];
		end
	end

	bphr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.level  (level_s1),
		.now    (now_s1),
		.cfg    (cfg),
		.ev     (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			event_q <= ev;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_TDATA_W-EVENT_W){1'b0}}, event_q};

	// every staged word that moves lands in the result register
	`BPHR_ASSERT_NEXT(a_advance_lands, advance, out_valid_q, "result word lost")
	// only defined event codes leave the block
	`BPHR_ASSERT_NOW(a_code_range, out_valid_q, event_q <= EV_RELEASE, "bad event code")
	// the input side only stalls while both registers are occupied
	`BPHR_ASSERT_NOW(a_stall_cause, !s_tready, valid_s1 && out_valid_q && !m_tready,
		"input stalled without cause")

endmodule

`default_nettype wire

// ----- bench/button_press_hold_repeat_detector_tb.sv -----
// self-checking bench for button_press_hold_repeat_detector: directed table, then random phases
// predicts untyped words from its debounce/hold/repeat model; depends on bphr_pkg and the rtl
`timescale 1ns / 1ps

module button_press_hold_repeat_detector_tb;
	import bphr_pkg::*;

	localparam int unsigned LATENCY     = 2;
	localparam int unsigned LIMIT       = 300000;
	localparam int unsigned MAX_REPORTS = 10;
	localparam int unsigned PHASES      = 8;
	localparam int unsigned PHASE_WORDS = 92;
	localparam int unsigned LONG_STALL  = 400;
	localparam int unsigned PAD_W       = S_TDATA_W - TIME_W - 1;

	// index 7 lies past the register list, writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = '1;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;   // pin_level, now_ms, zero pad
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;   // event_code, zero pad
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	button_press_hold_repeat_detector i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------- predictor
	cfg_t              cur_cfg;
	logic              settled;
	logic [TIME_W-1:0] last_change;
	logic [TIME_W-1:0] press_at;
	logic [TIME_W-1:0] repeat_at;
	logic              hold_pending;
	logic              holding;
	logic              repeating;

	event_t      pending_events[$];
	int unsigned ev_tally [1<<EVENT_W];
	int unsigned mismatches = 0;
	int unsigned words_sent = 0;
	int unsigned cycles = 0;
	int unsigned burst_left = 0;
	bit          stall_req = 1'b0;

	function automatic event_t debounce_step(logic raw, logic [TIME_W-1:0] stamp);
		logic              pressed;
		logic [TIME_W-1:0] span;
		event_t            ev;
		pressed = cur_cfg.active_low ? !raw : raw;
		ev = EV_NONE;
		if (pressed != settled) begin
			span = stamp - last_change;
			if (span > TIME_W'(cur_cfg.debounce_ms)) begin
				settled = pressed;
				if (pressed) begin
					if (cur_cfg.press_before_hold)
						ev = EV_PRESS;
					hold_pending = 1'b1;
					press_at = stamp;
				end else begin
					// a long press ends in release, a short one reports press here unless press_before_hold
					if (holding)
						ev = EV_RELEASE;
					else if (!cur_cfg.press_before_hold)
						ev = EV_PRESS;
					hold_pending = 1'b0;
					holding = 1'b0;
					repeating = 1'b0;
				end
			end
			// every observed change restarts the quiet window, accepted or not
			last_change = stamp;
		end
		// hold and repeat look at the raw pressed flag, not the settled one
		if (pressed) begin
			span = stamp - press_at;
			if (hold_pending && span >= TIME_W'(cur_cfg.hold_ms)) begin
				hold_pending = 1'b0;
				holding = 1'b1;
				ev = EV_HOLD;
				repeat_at = stamp;
				repeating = 1'b1;
			end
			span = stamp - repeat_at;
			if (repeating && span >= TIME_W'(cur_cfg.repeat_ms)) begin
				repeat_at = stamp;
				ev = EV_REPEAT;
			end
		end
		return ev;
	endfunction

	// ---------------------------------------------------------------- drivers
	// sender bursts: a random run of back-to-back words, then a random gap
	task automatic pace();
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
		end
		burst_left--;
	endtask

	// offer one word and wait for it to be taken; typed rows carry their own event
	task automatic offer(logic raw, logic [TIME_W-1:0] stamp, logic typed, event_t typed_ev);
		event_t ev;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {{PAD_W{1'b0}}, stamp, raw};
		do @(posedge clk); while (!s_tready);
		ev = debounce_step(raw, stamp);
		pending_events.push_back(typed ? typed_ev : ev);
		words_sent++;
	endtask

	// drop valid and let every expected word come back before touching registers
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (LATENCY + 3) @(posedge clk);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_ACTIVE_LOW:        cur_cfg.active_low = data[0];
			REG_DEBOUNCE_MS:       cur_cfg.debounce_ms = data;
			REG_HOLD_MS:           cur_cfg.hold_ms = data;
			REG_REPEAT_MS:         cur_cfg.repeat_ms = data;
			REG_PRESS_BEFORE_HOLD: cur_cfg.press_before_hold = data[0];
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// ---------------------------------------------------------------- directed table
	typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic                 raw;
		logic [TIME_W-1:0]    value;   // now_ms for a word, write data for a register
		logic                 typed;
		event_t               ev;
	} row_t;

	localparam int unsigned PLAN_ROWS = 33;
	localparam row_t PLAN [PLAN_ROWS] = '{
		// power-on settings: pull-up wiring, 50/200/100 ms, press on short release
		'{ROW_WORD, '0, 1'b1, 32'd0,    1'b1, EV_NONE},
		'{ROW_WORD, '0, 1'b0, 32'd100,  1'b0, EV_NONE},
		'{ROW_WORD, '0, 1'b0, 32'd300,  1'b1, EV_HOLD},
		'{ROW_WORD, '0, 1'b0, 32'd400,  1'b1, EV_REPEAT},
		'{ROW_WORD, '0, 1'b1, 32'd410,  1'b1, EV_RELEASE},
		// bouncing press inside the quiet window is dropped
		'{ROW_WORD, '0, 1'b0, 32'd420,  1'b0, EV_NONE},
		'{ROW_WORD, '0, 1'b1, 32'd430,  1'b0, EV_NONE},
		'{ROW_WORD, '0, 1'b0, 32'd500,  1'b0, EV_NONE},
		// unsettled release, then hold fires on the raw level
		'{ROW_WORD, '0, 1'b1, 32'd510,  1'b0, EV_NONE},
		'{ROW_WORD, '0, 1'b0, 32'd700,  1'b0, EV_NONE},
		'{ROW_WORD, '0, 1'b1, 32'd750,  1'b0, EV_NONE},
		'{ROW_WORD, '0, 1'b0, 32'd900,  1'b0, EV_NONE},
		'{ROW_WORD, '0, 1'b1, 32'd1000, 1'b1, EV_PRESS},
		// active high, zero debounce and repeat, press at the edge, spare index ignored
		'{ROW_REG, REG_ACTIVE_LOW,        1'b0, 32'hFE, 1'b0, EV_NONE},
		'{ROW_REG, REG_DEBOUNCE_MS,       1'b0, 32'h00, 1'b0, EV_NONE},
		'{ROW_REG, REG_REPEAT_MS,         1'b0, 32'h00, 1'b0, EV_NONE},
		'{ROW_REG, REG_PRESS_BEFORE_HOLD, 1'b0, 32'h81, 1'b0, EV_NONE},
		'{ROW_REG, REG_SPARE,             1'b0, 32'hFF, 1'b0, EV_NONE},
		'{ROW_WORD, '0, 1'b1, 32'd2000, 1'b1, EV_PRESS},
		'{ROW_WORD, '0, 1'b1, 32'd2200, 1'b1, EV_REPEAT},
		'{ROW_WORD, '0, 1'b0, 32'd2200, 1'b0, EV_NONE},
		// same-millisecond change with zero debounce is rejected
		'{ROW_WORD, '0, 1'b1, 32'd2200, 1'b0, EV_NONE},
		'{ROW_WORD, '0, 1'b1, 32'd2201, 1'b0, EV_NONE},
		// time stamp wraps through zero
		'{ROW_WORD, '0, 1'b0, 32'hFFFF_FFFF, 1'b0, EV_NONE},
		'{ROW_WORD, '0, 1'b1, 32'd5,    1'b0, EV_NONE},
		// widest windows
		'{ROW_REG, REG_DEBOUNCE_MS, 1'b0, 32'hFF, 1'b0, EV_NONE},
		'{ROW_REG, REG_HOLD_MS,     1'b0, 32'hFF, 1'b0, EV_NONE},
		'{ROW_REG, REG_REPEAT_MS,   1'b0, 32'hFF, 1'b0, EV_NONE},
		'{ROW_WORD, '0, 1'b1, 32'd260,  1'b0, EV_NONE},
		'{ROW_WORD, '0, 1'b1, 32'd515,  1'b0, EV_NONE},
		'{ROW_WORD, '0, 1'b0, 32'd600,  1'b0, EV_NONE},
		'{ROW_WORD, '0, 1'b0, 32'd855,  1'b0, EV_NONE},
		'{ROW_WORD, '0, 1'b1, 32'd856,  1'b0, EV_NONE}
	};

	// ---------------------------------------------------------------- stimulus
	initial begin : stimulus
		bit                writing;
		cfg_t              next_cfg;
		logic              raw;
		logic [TIME_W-1:0] stamp;
		logic [TIME_W-1:0] dt;
		int unsigned       bounce_left;
		int unsigned       pick;

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		cur_cfg   = '{active_low: 1'b1, debounce_ms: 8'd50, hold_ms: 8'd200,
			repeat_ms: 8'd100, press_before_hold: 1'b0};
		settled = 1'b0;
		last_change = '0;
		press_at = '0;
		repeat_at = '0;
		hold_pending = 1'b0;
		holding = 1'b0;
		repeating = 1'b0;
		foreach (ev_tally[i]) ev_tally[i] = 0;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		writing = 1'b0;
		foreach (PLAN[r]) begin
			if (PLAN[r].kind == ROW_REG) begin
				if (!writing)
					settle();
				set_reg(PLAN[r].idx, PLAN[r].value[CFG_DATA_W-1:0]);
				writing = 1'b1;
			end else begin
				if (writing)
					end_writes();
				writing = 1'b0;
				pace();
				offer(PLAN[r].raw, PLAN[r].value, PLAN[r].typed, PLAN[r].ev);
			end
		end

		// random phases: all-zero, all-max, power-on, then random settings
		for (int unsigned ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: next_cfg = '0;
				1: next_cfg = '{1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1};
				2: next_cfg = '{1'b1, 8'd50, 8'd200, 8'd100, 1'b0};
				default: next_cfg = '{1'($urandom_range(0, 1)), 8'($urandom_range(0, 80)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 160)),
					1'($urandom_range(0, 1))};
			endcase
			// single-bit registers get junk in the upper bits
			set_reg(REG_ACTIVE_LOW, {7'($urandom), next_cfg.active_low});
			set_reg(REG_DEBOUNCE_MS, next_cfg.debounce_ms);
			set_reg(REG_HOLD_MS, next_cfg.hold_ms);
			set_reg(REG_REPEAT_MS, next_cfg.repeat_ms);
			set_reg(REG_PRESS_BEFORE_HOLD, {7'($urandom), next_cfg.press_before_hold});
			if (ph >= 3)
				set_reg(REG_SPARE, 8'($urandom));
			end_writes();

			// one phase runs into a long result stall so the input side backs up
			if (ph == 3)
				stall_req = 1'b1;

			raw = 1'($urandom_range(0, 1));
			stamp = $urandom;
			bounce_left = 0;
			for (int unsigned k = 0; k < PHASE_WORDS; k++) begin
				if (bounce_left != 0) begin
					// contact bounce right after an intended change
					raw = ~raw;
					bounce_left--;
					dt = $urandom_range(0, cur_cfg.debounce_ms);
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 12)
						dt = '0;
					else if (pick < 50)
						dt = $urandom_range(1, 40);
					else if (pick < 85)
						dt = $urandom_range(1, 300);
					else if (pick < 95)
						dt = $urandom_range(1, 3000);
					else
						dt = $urandom;
					pick = $urandom_range(0, 99);
					if (pick < 8) begin
						raw = 1'($urandom_range(0, 1));
					end else if (pick < 22) begin
						raw = ~raw;
						bounce_left = $urandom_range(0, 3);
					end
				end
				stamp = stamp + dt;
				pace();
				offer(raw, stamp, 1'b0, EV_NONE);
			end
		end

		settle();
		if (pending_events.size() != 0)
			mismatches++;
		$display("covered %0d words, %0d register sets plus directed rows, %0d-cycle stall",
			words_sent, PHASES, LONG_STALL);
		$display("events seen: none %0d, press %0d, hold %0d, repeat %0d, release %0d",
			ev_tally[EV_NONE], ev_tally[EV_PRESS], ev_tally[EV_HOLD],
			ev_tally[EV_REPEAT], ev_tally[EV_RELEASE]);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// ---------------------------------------------------------------- receiver
	// stalls follow a rotating mask per segment; a request forces one long hold-off
	initial begin : receiver
		int unsigned seg;
		logic [7:0]  mask;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			seg = $urandom_range(16, 120);
			mask = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
			if (mask == 8'h00)
				mask = 8'h01;
			repeat (seg) begin
				@(negedge clk);
				if (stall_req) begin
					m_tready <= 1'b0;
					for (int unsigned c = 1; c < LONG_STALL; c++) @(negedge clk);
					stall_req = 1'b0;
				end else begin
					m_tready <= mask[0];
					mask = {mask[0], mask[7:1]};
				end
			end
		end
	end

	// ---------------------------------------------------------------- checker
	always @(posedge clk) begin : result_check
		event_t want;
		if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			if (pending_events.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result word 0x%02h with nothing pending", m_tdata);
			end else begin
				want = pending_events.pop_front();
				if (m_tdata !== {{(M_TDATA_W-EVENT_W){1'b0}}, want}) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("event mismatch: expected %s (0x%02h), got 0x%02h",
							want.name(), {{(M_TDATA_W-EVENT_W){1'b0}}, want}, m_tdata);
				end
				ev_tally[m_tdata[EVENT_W-1:0]]++;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles >= LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

endmodule
